>>> rtl/assert_macros.svh
// assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, quiet while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that post holds in the cycle after pre
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/sellm_pkg.sv
`timescale 1ns / 1ps
package sellm_pkg;

  localparam int W_W    = 16;
  localparam int CFG_W  = 32;
  localparam int A_W    = 38;
  localparam int K_W    = 46;
  localparam int P_W    = 70;
  localparam int Q_W    = 41;
  localparam int N2_W   = 44;
  localparam int RAD_W  = 36;
  localparam int ROOT_W = 18;
  localparam int MAG_W  = 60;

  localparam logic [13:0] K_MUL = 14'd15625;
  localparam logic [Q_W-1:0] TERM_CAP = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [ROOT_W-1:0] OUT_MAX = '1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOW = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef enum logic [2:0] {
    REG_MIN_WL = 3'd0,
    REG_MAX_WL = 3'd1,
    REG_B1     = 3'd2,
    REG_B2     = 3'd3,
    REG_C1     = 3'd4,
    REG_C2     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic neg;
    logic zero;
  } lane_info_t;

endpackage

>>> rtl/sellm_dly.sv
`timescale 1ns / 1ps
module sellm_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);
  logic [WIDTH-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
    end else if (en_i) begin
      line_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
    end
  end

  assign data_o = line_q[DEPTH-1];
endmodule

>>> rtl/sellm_div.sv
`timescale 1ns / 1ps
module sellm_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [sellm_pkg::P_W-1:0]   prod_i,
  input  logic [sellm_pkg::K_W-1:0]   dvs_i,
  input  sellm_pkg::lane_info_t       info_i,
  output logic [sellm_pkg::Q_W-1:0]   quo_o,
  output logic                        big_o,
  output sellm_pkg::lane_info_t       info_o
);
  import sellm_pkg::*;

  localparam int N = Q_W;

  logic [K_W-1:0] rem_q  [N+1];
  logic [Q_W-1:0] low_q  [N+1];
  logic [Q_W-1:0] quo_q  [N+1];
  logic [K_W-1:0] dvs_q  [N+1];
  logic           big_q  [N+1];
  lane_info_t     info_q [N+1];

  // quotient bits above the Q_W-bit result only show up as an overflow flag
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= K_W'(prod_i[P_W-1:Q_W]);
      big_q[0]  <= K_W'(prod_i[P_W-1:Q_W]) >= dvs_i;
      low_q[0]  <= prod_i[Q_W-1:0];
      quo_q[0]  <= '0;
      dvs_q[0]  <= dvs_i;
      info_q[0] <= info_i;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [K_W:0] trial;
    logic         ge;
    logic [K_W:0] diff;

    always_comb begin
      trial = {rem_q[j], low_q[j][Q_W-1]};
      ge    = trial >= {1'b0, dvs_q[j]};
      diff  = trial - {1'b0, dvs_q[j]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= ge ? diff[K_W-1:0] : trial[K_W-1:0];
        low_q[j+1]  <= {low_q[j][Q_W-2:0], 1'b0};
        quo_q[j+1]  <= {quo_q[j][Q_W-2:0], ge};
        dvs_q[j+1]  <= dvs_q[j];
        big_q[j+1]  <= big_q[j];
        info_q[j+1] <= info_q[j];
      end
    end
  end

  assign quo_o  = quo_q[N];
  assign big_o  = big_q[N];
  assign info_o = info_q[N];
endmodule

>>> rtl/sellm_sqrt.sv
`timescale 1ns / 1ps
module sellm_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [sellm_pkg::RAD_W-1:0]   rad_i,
  output logic [sellm_pkg::ROOT_W-1:0]  root_o
);
  import sellm_pkg::*;

  localparam int N   = ROOT_W;
  localparam int R_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_q  [N+1];
  logic [R_W-1:0]    rem_q  [N+1];
  logic [ROOT_W-1:0] root_q [N+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= rad_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [R_W+1:0] cur;
    logic [R_W+1:0] trial;
    logic           ge;

    always_comb begin
      cur   = {rem_q[j], rad_q[j][RAD_W-1 -: 2]};
      trial = (R_W+2)'({root_q[j], 2'b01});
      ge    = cur >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j+1]  <= {rad_q[j][RAD_W-3:0], 2'b00};
        rem_q[j+1]  <= ge ? R_W'(cur - trial) : R_W'(cur);
        root_q[j+1] <= {root_q[j][ROOT_W-2:0], ge};
      end
    end
  end

  assign root_o = root_q[N];
endmodule

>>> rtl/sellmeier_refractive_index.sv
// throughput: one beat per cycle unless a result beat is stalled; set by a
//   41-stage divider per term and an 18-stage square root pipeline, all advancing together
// a stalled result beat freezes the whole pipeline until taken
// reset: config returns to its reset values, pipeline and output empty
`timescale 1ns / 1ps
module sellmeier_refractive_index #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sellm_pkg::W_W-1:0]     wavelength_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sellm_pkg::ROOT_W-1:0]  index_value_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [sellm_pkg::CFG_W-1:0]   cfg_data_i
);
  import sellm_pkg::*;

  localparam int SH  = 2 * FRAC_BITS - 32;
  localparam int SHL = (SH > 0) ? SH : 0;
  localparam int SHR = (SH < 0) ? -SH : 0;
  localparam logic [ROOT_W-1:0] ONE_VAL =
    (FRAC_BITS >= ROOT_W) ? OUT_MAX : ROOT_W'(1 << FRAC_BITS);
  localparam int DIV_LAT = Q_W + 1;
  localparam int SQ_LAT  = ROOT_W + 1;
  localparam int SB_W    = 2 + ROOT_W + 2;

  logic [W_W-1:0]   min_wl_q, max_wl_q;
  logic [CFG_W-1:0] coef_b_q [2];
  logic [CFG_W-1:0] coef_c_q [2];
  logic [K_W-1:0]   k_q      [2];
  logic             en;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_wl_q    <= W_W'(5600);
      max_wl_q    <= W_W'(14400);
      coef_b_q[0] <= '0;
      coef_b_q[1] <= '0;
      coef_c_q[0] <= '0;
      coef_c_q[1] <= '0;
      k_q[0]      <= '0;
      k_q[1]      <= '0;
    end else begin
      k_q[0] <= K_W'(coef_c_q[0]) * K_W'(K_MUL);
      k_q[1] <= K_W'(coef_c_q[1]) * K_W'(K_MUL);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_MIN_WL: min_wl_q    <= cfg_data_i[W_W-1:0];
          REG_MAX_WL: max_wl_q    <= cfg_data_i[W_W-1:0];
          REG_B1:     coef_b_q[0] <= cfg_data_i;
          REG_B2:     coef_b_q[1] <= cfg_data_i;
          REG_C1:     coef_c_q[0] <= cfg_data_i;
          REG_C2:     coef_c_q[1] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // front stages: window check, lambda squared, numerator and denominator
  logic             v1_q, oow1_q, v2_q, oow2_q, v3_q, oow3_q, v4_q, oow4_q;
  logic [W_W-1:0]   w1_q;
  logic [A_W-1:0]   a2_q;
  logic [31:0]      wsq;
  logic [63:0]      plo3_q   [2];
  logic [A_W-1:0]   phi3_q   [2];
  logic [K_W-1:0]   d3_q     [2];
  lane_info_t       info3_q  [2];
  logic [P_W-1:0]   prod4_q  [2];
  logic [K_W-1:0]   d4_q     [2];
  lane_info_t       info4_q  [2];
  logic [K_W-1:0]   a_ext;

  assign wsq   = 32'(w1_q) * 32'(w1_q);
  assign a_ext = K_W'(a2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w1_q   <= wavelength_i;
      oow1_q <= (wavelength_i < min_wl_q) || (wavelength_i > max_wl_q);
      a2_q   <= {wsq, 6'b0};
      oow2_q <= oow1_q;
      oow3_q <= oow2_q;
      oow4_q <= oow3_q;
      for (int l = 0; l < 2; l++) begin
        plo3_q[l]       <= 64'(coef_b_q[l]) * 64'(a2_q[31:0]);
        phi3_q[l]       <= A_W'(coef_b_q[l]) * A_W'(a2_q[A_W-1:32]);
        info3_q[l].neg  <= a_ext < k_q[l];
        info3_q[l].zero <= a_ext == k_q[l];
        d3_q[l]         <= (a_ext < k_q[l]) ? (k_q[l] - a_ext) : (a_ext - k_q[l]);
        prod4_q[l]      <= P_W'(plo3_q[l]) + {phi3_q[l], 32'b0};
        d4_q[l]         <= d3_q[l];
        info4_q[l]      <= info3_q[l];
      end
    end
  end

  logic [Q_W-1:0] quo  [2];
  logic           big  [2];
  lane_info_t     info [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    sellm_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .prod_i (prod4_q[l]),
      .dvs_i  (d4_q[l]),
      .info_i (info4_q[l]),
      .quo_o  (quo[l]),
      .big_o  (big[l]),
      .info_o (info[l])
    );
  end

  logic [1:0] ctl_div;
  sellm_dly #(.WIDTH(2), .DEPTH(DIV_LAT)) u_dly_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .data_i ({v4_q, oow4_q}),
    .data_o (ctl_div)
  );

  // sum of terms
  logic                   tsat  [2];
  logic [Q_W-1:0]         tmag  [2];
  logic signed [N2_W-1:0] term  [2];
  logic                   v5_q, oow5_q, zero5_q, sat5_q;
  logic signed [N2_W-1:0] n2_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      tsat[l] = !info[l].zero && (big[l] || (quo[l] > TERM_CAP));
      tmag[l] = info[l].zero ? '0 : (tsat[l] ? TERM_CAP : quo[l]);
      term[l] = info[l].neg ? -$signed(N2_W'(tmag[l])) : $signed(N2_W'(tmag[l]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= ctl_div[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oow5_q  <= ctl_div[0];
      zero5_q <= info[0].zero || info[1].zero;
      sat5_q  <= tsat[0] || tsat[1];
      n2_q    <= $signed(N2_W'(64'd1 << 32)) + term[0] + term[1];
    end
  end

  // special cases decided ahead of the root
  logic [MAG_W-1:0]  mag;
  logic              byp;
  logic [ROOT_W-1:0] bval;
  logic [1:0]        bst;
  logic              v6_q;
  logic [RAD_W-1:0]  rad6_q;
  logic [SB_W-2:0]   sb6_q;

  assign mag = (MAG_W'(n2_q[N2_W-2:0]) << SHL) >> SHR;

  always_comb begin
    byp  = 1'b1;
    bval = OUT_MAX;
    bst  = ST_SAT;
    if (oow5_q) begin
      bval = ONE_VAL;
      bst  = ST_OOW;
    end else if (zero5_q) begin
      bval = OUT_MAX;
    end else if (sat5_q) begin
      bval = n2_q[N2_W-1] ? '0 : OUT_MAX;
    end else if (n2_q[N2_W-1]) begin
      bval = '0;
    end else if (|mag[MAG_W-1:RAD_W]) begin
      bval = OUT_MAX;
    end else begin
      byp = 1'b0;
      bst = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad6_q <= mag[RAD_W-1:0];
      sb6_q  <= {byp, bval, bst};
    end
  end

  logic [ROOT_W-1:0] root;
  logic [SB_W-1:0]   sb_sq;

  sellm_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad6_q),
    .root_o (root)
  );

  sellm_dly #(.WIDTH(SB_W), .DEPTH(SQ_LAT)) u_dly_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .data_i ({v6_q, sb6_q}),
    .data_o (sb_sq)
  );

  logic              out_valid_q;
  logic [ROOT_W-1:0] index_q;
  logic [1:0]        status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sb_sq[SB_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      index_q  <= sb_sq[SB_W-2] ? sb_sq[ROOT_W+1:2] : root;
      status_q <= sb_sq[1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign index_value_o = index_q;
  assign status_o      = status_q;
endmodule

>>> rtl/sellm_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sellm_chk #(
  parameter int FRAC_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [sellm_pkg::ROOT_W-1:0]  index_value_o,
  input logic [1:0]                    status_o
);
  import sellm_pkg::*;

  localparam logic [ROOT_W-1:0] ONE_VAL =
    (FRAC_BITS >= ROOT_W) ? OUT_MAX : ROOT_W'(1 << FRAC_BITS);

  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(index_value_o) && $stable(status_o),
    "result beat changed under stall")
  `ASSERT_CLK(a_status_code, out_valid_o |-> (status_o != 2'd3), "undefined status code")
  `ASSERT_CLK(a_oow_one,
    (out_valid_o && status_o == ST_OOW) |-> (index_value_o == ONE_VAL),
    "out of window beat is not one")
  `ASSERT_CLK(a_ready_free, !out_valid_o |-> in_ready_o, "input stalled with empty output")
endmodule

bind sellmeier_refractive_index sellm_chk #(.FRAC_BITS(FRAC_BITS)) u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .index_value_o (index_value_o),
  .status_o      (status_o)
);
